[design/car_pkg.sv]
// Shared types, constants and helpers for the CIGAR alignment rescorer.
// Used by every module of the block; depends on nothing.
package car_pkg;

    // Longest read the block scores; longer read lengths are clamped to it.
    localparam int unsigned MAX_READ_LENGTH = 1023;

    // Item codes
    typedef enum logic [1:0] {
        OP_PAIR   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_FINISH = 2'd3
    } t_op;

    // Scoring modes; the fourth code scores like fast
    localparam logic [1:0] MODE_NORMAL    = 2'd0;
    localparam logic [1:0] MODE_FAST      = 2'd1;
    localparam logic [1:0] MODE_VERY_FAST = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_MODE            = 3'd0;
    localparam logic [2:0] CFG_MATCH_REWARD    = 3'd1;
    localparam logic [2:0] CFG_MISMATCH_CHARGE = 3'd2;
    localparam logic [2:0] CFG_PLAIN_MATCH     = 3'd3;
    localparam logic [2:0] CFG_PLAIN_MISMATCH  = 3'd4;
    localparam logic [2:0] CFG_GAP_OPEN        = 3'd5;
    localparam logic [2:0] CFG_GAP_EXTEND      = 3'd6;

    // Configuration reset values
    localparam logic [1:0] RST_MODE            = MODE_NORMAL;
    localparam logic [6:0] RST_MATCH_REWARD    = 7'd1;
    localparam logic [6:0] RST_MISMATCH_CHARGE = 7'd3;
    localparam logic [7:0] RST_PLAIN_MATCH     = 8'd0;
    localparam logic [7:0] RST_PLAIN_MISMATCH  = 8'd15;
    localparam logic [7:0] RST_GAP_OPEN        = 8'd40;
    localparam logic [7:0] RST_GAP_EXTEND      = 8'd6;

    // Fixed gap charges of the fast modes
    localparam int unsigned FAST_GAP_OPEN = 40;
    localparam int unsigned FAST_GAP_EXT  = 6;

    // Accumulator widths: stored, per-item charge, and pre-saturation sum
    localparam int unsigned ACC_W   = 21;
    localparam int unsigned DELTA_W = 22;
    localparam int unsigned SUM_W   = 23;
    localparam logic signed [SUM_W-1:0] SUM_MAX = 23'sd1048575;
    localparam logic signed [SUM_W-1:0] SUM_MIN = -23'sd1048576;

    typedef struct packed {
        logic [1:0]        mode;
        logic [6:0]        match_reward;
        logic [6:0]        mismatch_charge;
        logic signed [7:0] plain_match;
        logic signed [7:0] plain_mismatch;
        logic [7:0]        open_cost;
        logic [7:0]        gap_extend;
    } t_cfg;

    typedef struct packed {
        t_op        op;
        logic [1:0] ref_base;
        logic [1:0] read_base;
        logic [9:0] run_length;
        logic [9:0] read_length;
    } t_item;

    // Charges one item applies to the two accumulators
    typedef struct packed {
        logic signed [DELTA_W-1:0] main_delta;
        logic signed [DELTA_W-1:0] sec_delta;
        logic                      length_error;
    } t_charge;

    // Accumulator add, saturating at the 21-bit signed range
    function automatic logic signed [ACC_W-1:0] sat_acc(
        input logic signed [ACC_W-1:0]   acc,
        input logic signed [DELTA_W-1:0] delta
    );
        logic signed [SUM_W-1:0] a_ext;
        logic signed [SUM_W-1:0] d_ext;
        logic signed [SUM_W-1:0] s;
        a_ext = {{(SUM_W-ACC_W){acc[ACC_W-1]}}, acc};
        d_ext = {{(SUM_W-DELTA_W){delta[DELTA_W-1]}}, delta};
        s = a_ext + d_ext;
        if (s > SUM_MAX) begin
            return SUM_MAX[ACC_W-1:0];
        end else if (s < SUM_MIN) begin
            return SUM_MIN[ACC_W-1:0];
        end
        return s[ACC_W-1:0];
    endfunction

    // 10-bit counter add, saturating at all ones
    function automatic logic [9:0] sat10_add(input logic [9:0] a, input logic [9:0] b);
        logic [10:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[10] ? 10'h3ff : s[9:0];
    endfunction

    // 11-bit counter add, saturating at all ones
    function automatic logic [10:0] sat11_add(input logic [10:0] a, input logic [9:0] b);
        logic [11:0] s;
        s = {1'b0, a} + {2'b0, b};
        return s[11] ? 11'h7ff : s[10:0];
    endfunction

endpackage

[design/car_cfg_regs.sv]
// Configuration register file of the rescorer.
// Depends on car_pkg for the register indexes, reset values and t_cfg.
module car_cfg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_data,
    output car_pkg::t_cfg       o_cfg
);

    car_pkg::t_cfg r_cfg;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode            <= car_pkg::RST_MODE;
            r_cfg.match_reward    <= car_pkg::RST_MATCH_REWARD;
            r_cfg.mismatch_charge <= car_pkg::RST_MISMATCH_CHARGE;
            r_cfg.plain_match     <= car_pkg::RST_PLAIN_MATCH;
            r_cfg.plain_mismatch  <= car_pkg::RST_PLAIN_MISMATCH;
            r_cfg.open_cost       <= car_pkg::RST_GAP_OPEN;
            r_cfg.gap_extend      <= car_pkg::RST_GAP_EXTEND;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                car_pkg::CFG_MODE:            r_cfg.mode            <= i_cfg_data[1:0];
                car_pkg::CFG_MATCH_REWARD:    r_cfg.match_reward    <= i_cfg_data[6:0];
                car_pkg::CFG_MISMATCH_CHARGE: r_cfg.mismatch_charge <= i_cfg_data[6:0];
                car_pkg::CFG_PLAIN_MATCH:     r_cfg.plain_match     <= i_cfg_data;
                car_pkg::CFG_PLAIN_MISMATCH:  r_cfg.plain_mismatch  <= i_cfg_data;
                car_pkg::CFG_GAP_OPEN:        r_cfg.open_cost       <= i_cfg_data;
                car_pkg::CFG_GAP_EXTEND:      r_cfg.gap_extend      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[design/car_input_reg.sv]
// Input register stage: captures one beat and releases it to the accumulators.
// Depends on car_pkg for t_item and the item codes.
module car_input_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  car_pkg::t_item  i_item,
    input  logic            i_out_free,
    output logic            o_go,
    output car_pkg::t_item  o_item
);

    logic           r_valid;
    car_pkg::t_item r_item;
    logic           go;
    logic           take;

    // Only a finish beat needs room in the result register
    assign go   = r_valid && ((r_item.op != car_pkg::OP_FINISH) || i_out_free);
    assign o_in_ready = !r_valid || go;
    assign take = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= take || (r_valid && !go);
        end
    end

    // Payload; cleared at reset so the decode downstream never sees an unknown code
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item <= '0;
        end else if (take) begin
            r_item <= i_item;
        end
    end

    assign o_go   = go;
    assign o_item = r_item;

endmodule

[design/car_charge_calc.sv]
// Per-item score charges: pair scores, gap charges and the trailing penalty.
// Depends on car_pkg for t_item, t_cfg, t_charge and the mode codes.
module car_charge_calc (
    input  car_pkg::t_item   i_item,
    input  car_pkg::t_cfg    i_cfg,
    input  logic [10:0]      i_covered,
    output car_pkg::t_charge o_charge
);

    logic        is_pair;
    logic        is_run;
    logic        diff;
    logic        fast;
    logic [9:0]  rlen;
    logic        trail;
    logic [10:0] uncov;
    logic [9:0]  gap_len;
    logic        gap_on;
    logic [12:0] fast_charge;
    logic [17:0] ext_prod;
    logic [21:0] norm_charge;

    // Item decode
    assign is_pair = (i_item.op == car_pkg::OP_PAIR);
    assign is_run  = (i_item.op == car_pkg::OP_INSERT) || (i_item.op == car_pkg::OP_DELETE);
    assign diff    = (i_item.ref_base != i_item.read_base);
    assign fast    = (i_cfg.mode != car_pkg::MODE_NORMAL);

    // Read length clamp and uncovered tail
    assign rlen  = ({22'd0, i_item.read_length} > car_pkg::MAX_READ_LENGTH)
                   ? 10'(car_pkg::MAX_READ_LENGTH) : i_item.read_length;
    assign trail = (i_item.op == car_pkg::OP_FINISH) && (i_covered < {1'b0, rlen});
    assign uncov = {1'b0, rlen} - i_covered;

    assign gap_len = is_run ? i_item.run_length : uncov[9:0];
    assign gap_on  = is_run || trail;

    // Gap charges: fixed affine in fast modes, configured affine in normal mode.
    // In normal mode a run pays open+(len-1)*extend, the tail open+len*extend.
    assign fast_charge = 13'(car_pkg::FAST_GAP_OPEN) + 13'(gap_len) * 13'(car_pkg::FAST_GAP_EXT);
    assign ext_prod    = 18'(gap_len) * 18'(i_cfg.gap_extend);
    assign norm_charge = {4'd0, ext_prod} + {14'd0, i_cfg.open_cost}
                         - (is_run ? {14'd0, i_cfg.gap_extend} : 22'd0);

    // Charge selection
    always_comb begin
        o_charge.main_delta   = '0;
        o_charge.sec_delta    = '0;
        o_charge.length_error = (i_covered > {1'b0, rlen});
        if (is_pair) begin
            if (i_cfg.mode == car_pkg::MODE_VERY_FAST) begin
                o_charge.sec_delta = diff ? (22'd0 - {15'd0, i_cfg.mismatch_charge})
                                          : {15'd0, i_cfg.match_reward};
            end else begin
                o_charge.main_delta = diff
                    ? {{14{i_cfg.plain_mismatch[7]}}, i_cfg.plain_mismatch}
                    : {{14{i_cfg.plain_match[7]}}, i_cfg.plain_match};
            end
        end else if (gap_on) begin
            if (fast) begin
                o_charge.main_delta = {9'd0, fast_charge};
            end else begin
                o_charge.sec_delta = 22'd0 - norm_charge;
            end
        end
    end

endmodule

[design/car_accum.sv]
// Counters, score accumulators and the result register of the rescorer.
// Depends on car_pkg for t_item, t_charge and the saturating helpers.
module car_accum (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  car_pkg::t_item      i_item,
    input  car_pkg::t_charge    i_charge,
    output logic [10:0]         o_covered,
    output logic                o_out_free,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [9:0]          o_matched_columns,
    output logic [9:0]          o_inserted_bases,
    output logic [9:0]          o_mismatches,
    output logic [9:0]          o_indel_runs,
    output logic [10:0]         o_covered_length,
    output logic signed [20:0]  o_main_score,
    output logic signed [20:0]  o_secondary_score,
    output logic                o_length_error
);

    // Running state
    logic [9:0]         r_match, n_match;
    logic [9:0]         r_insert, n_insert;
    logic [9:0]         r_mismatch, n_mismatch;
    logic [9:0]         r_indel, n_indel;
    logic [10:0]        r_covered, n_covered;
    logic signed [20:0] r_score, n_score;
    logic signed [20:0] r_sec, n_sec;

    // Result register
    logic               r_out_valid;
    logic [9:0]         r_out_match;
    logic [9:0]         r_out_insert;
    logic [9:0]         r_out_mismatch;
    logic [9:0]         r_out_indel;
    logic [10:0]        r_out_covered;
    logic signed [20:0] r_out_score;
    logic signed [20:0] r_out_sec;
    logic               r_out_len_err;

    logic               is_finish;
    logic               emit;

    assign is_finish  = (i_item.op == car_pkg::OP_FINISH);
    assign emit       = i_go && is_finish;
    assign o_out_free = !r_out_valid || i_out_ready;

    // Per-item state update (before the finish clear)
    always_comb begin
        n_match    = r_match;
        n_insert   = r_insert;
        n_mismatch = r_mismatch;
        n_indel    = r_indel;
        n_covered  = r_covered;
        n_score    = car_pkg::sat_acc(r_score, i_charge.main_delta);
        n_sec      = car_pkg::sat_acc(r_sec, i_charge.sec_delta);
        unique case (i_item.op)
            car_pkg::OP_PAIR: begin
                n_match   = car_pkg::sat10_add(r_match, 10'd1);
                n_covered = car_pkg::sat11_add(r_covered, 10'd1);
                if (i_item.ref_base != i_item.read_base) begin
                    n_mismatch = car_pkg::sat10_add(r_mismatch, 10'd1);
                end
            end
            car_pkg::OP_INSERT: begin
                n_covered = car_pkg::sat11_add(r_covered, i_item.run_length);
                n_insert  = car_pkg::sat10_add(r_insert, i_item.run_length);
                n_indel   = car_pkg::sat10_add(r_indel, 10'd1);
            end
            car_pkg::OP_DELETE: begin
                n_indel = car_pkg::sat10_add(r_indel, 10'd1);
            end
            car_pkg::OP_FINISH: ;
        endcase
    end

    // State registers; a finish clears them after the totals are taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || emit) begin
            r_match    <= '0;
            r_insert   <= '0;
            r_mismatch <= '0;
            r_indel    <= '0;
            r_covered  <= '0;
            r_score    <= '0;
            r_sec      <= '0;
        end else if (i_go) begin
            r_match    <= n_match;
            r_insert   <= n_insert;
            r_mismatch <= n_mismatch;
            r_indel    <= n_indel;
            r_covered  <= n_covered;
            r_score    <= n_score;
            r_sec      <= n_sec;
        end
    end

    // Result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_match    <= n_match;
            r_out_insert   <= n_insert;
            r_out_mismatch <= n_mismatch;
            r_out_indel    <= n_indel;
            r_out_covered  <= n_covered;
            r_out_score    <= n_score;
            r_out_sec      <= n_sec;
            r_out_len_err  <= i_charge.length_error;
        end
    end

    assign o_covered         = r_covered;
    assign o_out_valid       = r_out_valid;
    assign o_matched_columns = r_out_match;
    assign o_inserted_bases  = r_out_insert;
    assign o_mismatches      = r_out_mismatch;
    assign o_indel_runs      = r_out_indel;
    assign o_covered_length  = r_out_covered;
    assign o_main_score      = r_out_score;
    assign o_secondary_score = r_out_sec;
    assign o_length_error    = r_out_len_err;

    // A finish never lands on a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (!r_out_valid || i_out_ready))
        else $error("finish overwrote a pending result");

    // A result appears only right after a finish beat
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(emit))
        else $error("result valid without a finish");

    // State is cleared after every finish
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (r_match == 10'd0) && (r_covered == 11'd0) && (r_score == 21'sd0)
                 && (r_sec == 21'sd0))
        else $error("state not cleared after finish");

    // Mismatches are a subset of the aligned pairs, which are part of the coverage
    a_count_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_mismatch <= r_out_match)
                        && ({1'b0, r_out_match} <= r_out_covered))
        else $error("inconsistent result counts");

endmodule

[design/cigar_alignment_rescorer.sv]
// Rescores an alignment streamed as pairs, insertion runs, deletion runs and a finish
// beat; takes one beat per cycle through an input register and the accumulators. A finish
// beat's totals are written to the result register when the beat leaves the input
// register and are held there until the result handshake.
// The input side stalls only when a finish beat meets a result that has not been taken;
// every other beat passes a waiting result. Configuration is a plain write port (no
// read-back) and is expected to change only while no beat is in flight.
// Top level; depends on car_pkg, car_cfg_regs, car_input_reg, car_charge_calc, car_accum.
module cigar_alignment_rescorer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    // item channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_op,
    input  logic [1:0]         i_ref_base,
    input  logic [1:0]         i_read_base,
    input  logic [9:0]         i_run_length,
    input  logic [9:0]         i_read_length,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [9:0]         o_matched_columns,
    output logic [9:0]         o_inserted_bases,
    output logic [9:0]         o_mismatches,
    output logic [9:0]         o_indel_runs,
    output logic [10:0]        o_covered_length,
    output logic signed [20:0] o_main_score,
    output logic signed [20:0] o_secondary_score,
    output logic               o_length_error
);

    car_pkg::t_cfg    cfg;
    car_pkg::t_item   in_item;
    car_pkg::t_item   cur_item;
    car_pkg::t_charge charge;
    logic             go;
    logic             out_free;
    logic [10:0]      covered;

    // Pack the input beat
    assign in_item.op          = car_pkg::t_op'(i_op);
    assign in_item.ref_base    = i_ref_base;
    assign in_item.read_base   = i_read_base;
    assign in_item.run_length  = i_run_length;
    assign in_item.read_length = i_read_length;

    car_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    car_input_reg u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_item     (in_item),
        .i_out_free (out_free),
        .o_go       (go),
        .o_item     (cur_item)
    );

    car_charge_calc u_charge (
        .i_item    (cur_item),
        .i_cfg     (cfg),
        .i_covered (covered),
        .o_charge  (charge)
    );

    car_accum u_acc (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_go              (go),
        .i_item            (cur_item),
        .i_charge          (charge),
        .o_covered         (covered),
        .o_out_free        (out_free),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_matched_columns (o_matched_columns),
        .o_inserted_bases  (o_inserted_bases),
        .o_mismatches      (o_mismatches),
        .o_indel_runs      (o_indel_runs),
        .o_covered_length  (o_covered_length),
        .o_main_score      (o_main_score),
        .o_secondary_score (o_secondary_score),
        .o_length_error    (o_length_error)
    );

endmodule
